>>> sv/pidtaw_pkg.sv
package pidtaw_pkg;

    localparam int W  = 32;
    localparam int F  = 16;
    localparam int AW = W + 1;
    localparam int MW = AW + W;
    localparam int DN = W + 1 + F;
    localparam int DT_W = W - 1;
    localparam int IN_TW  = ((W + DT_W + 7) / 8) * 8;
    localparam int OUT_TW = ((W + 4 + 7) / 8) * 8;
    localparam int CFG_IW = 3;
    localparam int DIV_CW = $clog2(DN);

    localparam logic [CFG_IW-1:0] REG_GP   = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_GI   = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_GD   = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_TGT  = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_OMAX = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] REG_OMIN = CFG_IW'(5);

    localparam logic [2:0] A_SUM  = 3'd0;
    localparam logic [2:0] A_E    = 3'd1;
    localparam logic [2:0] A_GP   = 3'd2;
    localparam logic [2:0] A_GI   = 3'd3;
    localparam logic [2:0] A_GD   = 3'd4;
    localparam logic [2:0] A_DER  = 3'd5;
    localparam logic [2:0] A_MRES = 3'd6;

    localparam logic [1:0] B_DT  = 2'd0;
    localparam logic [1:0] B_E   = 2'd1;
    localparam logic [1:0] B_INT = 2'd2;
    localparam logic [1:0] B_DER = 2'd3;

    localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

    localparam logic signed [W+11:0] ONE_X  = (W+12)'(1) << F;
    localparam logic signed [W+11:0] LIM_X  = (W+12)'(1023) << F;
    localparam logic signed [W+11:0] SMAX_X = {13'd0, {(W-1){1'b1}}};
    localparam logic signed [W+11:0] SMIN_X = {13'h1fff, {(W-1){1'b0}}};
    localparam logic [W-1:0] GP_RST   = (ONE_X > SMAX_X) ? SMAX_X[W-1:0] : ONE_X[W-1:0];
    localparam logic [W-1:0] OMAX_RST = (LIM_X > SMAX_X) ? SMAX_X[W-1:0] : LIM_X[W-1:0];
    localparam logic [W-1:0] OMIN_RST = (-LIM_X < SMIN_X) ? SMIN_X[W-1:0] : W'(-LIM_X);

    typedef struct packed {
        logic       cap;
        logic       mul_go;
        logic [2:0] a_sel;
        logic [1:0] b_sel;
        logic       sh1;
        logic       mul_fin;
        logic       integ;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       raw_load;
        logic       raw_add;
        logic       chk;
        logic       edt_save;
        logic       back;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic dt_zero;
        logic hit;
    } t_stat;

    typedef struct packed {
        logic         flag;
        logic [W-1:0] val;
    } t_sat;

    function automatic t_sat sat_w(input logic signed [W+1:0] x);
        t_sat s;
        s.flag = 1'b0;
        s.val  = x[W-1:0];
        if (x > SMAX) begin
            s.flag = 1'b1;
            s.val  = SMAX[W-1:0];
        end else if (x < SMIN) begin
            s.flag = 1'b1;
            s.val  = SMIN[W-1:0];
        end
        return s;
    endfunction

endpackage

>>> sv/pidtaw_ctrl.sv
module pidtaw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  pidtaw_pkg::t_stat i_stat,
    output pidtaw_pkg::t_cmd  o_cmd
);
    import pidtaw_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_TRAP_M  = 5'd1;
    localparam logic [4:0] ST_TRAP_S  = 5'd2;
    localparam logic [4:0] ST_INTEG   = 5'd3;
    localparam logic [4:0] ST_DIV     = 5'd4;
    localparam logic [4:0] ST_DIV_FIN = 5'd5;
    localparam logic [4:0] ST_P_M     = 5'd6;
    localparam logic [4:0] ST_P_S     = 5'd7;
    localparam logic [4:0] ST_I_M     = 5'd8;
    localparam logic [4:0] ST_I_S     = 5'd9;
    localparam logic [4:0] ST_D_M     = 5'd10;
    localparam logic [4:0] ST_D_S     = 5'd11;
    localparam logic [4:0] ST_SUM     = 5'd12;
    localparam logic [4:0] ST_CHK     = 5'd13;
    localparam logic [4:0] ST_E_M     = 5'd14;
    localparam logic [4:0] ST_E_S     = 5'd15;
    localparam logic [4:0] ST_T_M     = 5'd16;
    localparam logic [4:0] ST_T_S     = 5'd17;
    localparam logic [4:0] ST_T2_M    = 5'd18;
    localparam logic [4:0] ST_T2_S    = 5'd19;
    localparam logic [4:0] ST_BACK    = 5'd20;
    localparam logic [4:0] ST_OUT     = 5'd21;

    logic [4:0]        r_state, n_state;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;
    t_cmd              cmd;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_cmd      = cmd;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.cap = 1'b1;
                    n_state = ST_TRAP_M;
                end
            end
            ST_TRAP_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_SUM; cmd.b_sel = B_DT; cmd.sh1 = 1'b1;
                n_state = ST_TRAP_S;
            end
            ST_TRAP_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ = 1'b1;
                if (i_stat.dt_zero) begin
                    n_state = ST_P_M;
                end else begin
                    cmd.div_init = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt = r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(DN - 1)) begin
                    n_state = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN: begin
                cmd.div_fin = 1'b1;
                n_state = ST_P_M;
            end
            ST_P_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_GP; cmd.b_sel = B_E;
                n_state = ST_P_S;
            end
            ST_P_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_I_M;
            end
            ST_I_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_GI; cmd.b_sel = B_INT;
                cmd.raw_load = 1'b1;
                n_state = ST_I_S;
            end
            ST_I_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_D_M;
            end
            ST_D_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_GD; cmd.b_sel = B_DER;
                cmd.raw_add = 1'b1;
                n_state = ST_D_S;
            end
            ST_D_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                cmd.raw_add = 1'b1;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk = 1'b1;
                n_state = i_stat.hit ? ST_E_M : ST_OUT;
            end
            ST_E_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_E; cmd.b_sel = B_DT;
                n_state = ST_E_S;
            end
            ST_E_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_T_M;
            end
            ST_T_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_DER; cmd.b_sel = B_DT;
                cmd.edt_save = 1'b1;
                n_state = ST_T_S;
            end
            ST_T_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_T2_M;
            end
            ST_T2_M: begin
                cmd.mul_go = 1'b1; cmd.a_sel = A_MRES; cmd.b_sel = B_DT;
                n_state = ST_T2_S;
            end
            ST_T2_S: begin
                cmd.mul_fin = 1'b1;
                n_state = ST_BACK;
            end
            ST_BACK: begin
                cmd.back = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

>>> sv/pidtaw_dp.sv
module pidtaw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pidtaw_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  logic [pidtaw_pkg::W-1:0]            i_cfg_data,
    input  logic [pidtaw_pkg::IN_TW-1:0]        i_s_tdata,
    input  pidtaw_pkg::t_cmd                    i_cmd,
    output pidtaw_pkg::t_stat                   o_stat,
    output logic [pidtaw_pkg::OUT_TW-1:0]       o_m_tdata
);
    import pidtaw_pkg::*;

    logic signed [W-1:0]  r_gp, r_gi, r_gd, r_tgt, r_omax, r_omin;
    logic signed [W-1:0]  r_integ, r_last, r_e, r_mres, r_deriv, r_edt;
    logic signed [AW-1:0] r_sum, r_diff;
    logic [DT_W-1:0]      r_dt;
    logic                 r_zero, r_sat, r_above, r_below, r_neg, r_sh1, r_dneg;
    logic [MW-1:0]        r_prod;
    logic signed [W+1:0]  r_raw;
    logic [DN-1:0]        r_num;
    logic [W-1:0]         r_rem;
    logic [OUT_TW-1:0]    r_out;

    logic signed [W-1:0]  meas;
    logic [DT_W-1:0]      dt_in;
    logic signed [W+1:0]  e_full;
    t_sat                 e_sat, integ_sat, back_sat, drive_sat;
    logic signed [W-1:0]  e_c;
    logic signed [AW-1:0] a_val;
    logic signed [W-1:0]  b_val;
    logic [AW-1:0]        ma;
    logic [W-1:0]         mb;
    logic [MW-1:0]        shifted;
    logic [MW-1:0]        mlim;
    logic [W-1:0]         mlo;
    logic [W:0]           dtrial;
    logic                 dbit;
    logic [DN-1:0]        qlim;
    logic [DN-1:0]        qv;
    logic signed [W+1:0]  raw_ext_max, raw_ext_min, back_x;
    logic                 above, below;

    assign meas   = i_s_tdata[W-1:0];
    assign dt_in  = i_s_tdata[W+DT_W-1:W];
    assign e_full = (W+2)'(r_tgt) - (W+2)'(meas);
    assign e_sat  = sat_w(e_full);
    assign e_c    = e_sat.val;

    always_comb begin
        case (i_cmd.a_sel)
            A_SUM:   a_val = r_sum;
            A_E:     a_val = AW'(r_e);
            A_GP:    a_val = AW'(r_gp);
            A_GI:    a_val = AW'(r_gi);
            A_GD:    a_val = AW'(r_gd);
            A_DER:   a_val = AW'(r_deriv);
            A_MRES:  a_val = AW'(r_mres);
            default: a_val = '0;
        endcase
        case (i_cmd.b_sel)
            B_DT:    b_val = {1'b0, r_dt};
            B_E:     b_val = r_e;
            B_INT:   b_val = r_integ;
            default: b_val = r_deriv;
        endcase
    end

    assign ma = a_val[AW-1] ? AW'(-a_val) : AW'(a_val);
    assign mb = b_val[W-1] ? W'(-b_val) : W'(b_val);

    // Product is rounded toward zero by shifting its magnitude, then clamped.
    assign shifted = r_sh1 ? (r_prod >> (F + 1)) : (r_prod >> F);
    assign mlim    = r_neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    assign mlo     = (shifted > mlim) ? mlim[W-1:0] : shifted[W-1:0];

    assign integ_sat = sat_w((W+2)'(r_integ) + (W+2)'(r_mres));

    assign dtrial = {r_rem, r_num[DN-1]};
    assign dbit   = (dtrial >= (W+1)'(r_dt));
    assign qlim   = r_dneg ? (DN'(1) << (W - 1)) : ((DN'(1) << (W - 1)) - DN'(1));
    assign qv     = (r_num > qlim) ? qlim : r_num;

    assign raw_ext_max = (W+2)'(r_omax);
    assign raw_ext_min = (W+2)'(r_omin);
    assign above = (r_raw > raw_ext_max);
    assign below = !above && (r_raw < raw_ext_min);
    assign drive_sat = sat_w(r_raw);

    always_comb begin
        if (r_above) begin
            back_x = raw_ext_max - (W+2)'(r_edt) - (W+2)'(r_mres);
        end else begin
            back_x = raw_ext_min + (W+2)'(r_edt) + (W+2)'(r_mres);
        end
    end
    assign back_sat = sat_w(back_x);

    assign o_stat.dt_zero = r_zero;
    assign o_stat.hit     = above || below;
    assign o_m_tdata      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= GP_RST;
            r_gi    <= '0;
            r_gd    <= '0;
            r_tgt   <= '0;
            r_omax  <= OMAX_RST;
            r_omin  <= OMIN_RST;
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GP:   r_gp   <= i_cfg_data;
                    REG_GI:   r_gi   <= i_cfg_data;
                    REG_GD:   r_gd   <= i_cfg_data;
                    REG_TGT:  r_tgt  <= i_cfg_data;
                    REG_OMAX: r_omax <= i_cfg_data;
                    REG_OMIN: r_omin <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.integ) begin
                r_integ <= integ_sat.val;
            end else if (i_cmd.back) begin
                r_integ <= back_sat.val;
            end
            if (i_cmd.chk) begin
                r_last <= r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_e     <= e_c;
            r_sum   <= AW'(e_c) + AW'(r_last);
            r_diff  <= AW'(e_c) - AW'(r_last);
            r_dt    <= dt_in;
            r_zero  <= (dt_in == '0);
            r_sat   <= e_sat.flag;
            r_above <= 1'b0;
            r_below <= 1'b0;
            r_deriv <= '0;
        end
        if (i_cmd.mul_go) begin
            r_prod <= MW'(ma) * MW'(mb);
            r_neg  <= a_val[AW-1] ^ b_val[W-1];
            r_sh1  <= i_cmd.sh1;
        end
        if (i_cmd.mul_fin) begin
            r_mres <= r_neg ? W'(-mlo) : mlo;
            if (shifted > mlim) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.integ && integ_sat.flag) begin
            r_sat <= 1'b1;
        end
        if (i_cmd.div_init) begin
            r_dneg <= r_diff[AW-1];
            r_num  <= {(r_diff[AW-1] ? AW'(-r_diff) : AW'(r_diff)), {F{1'b0}}};
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dbit ? W'(dtrial - (W+1)'(r_dt)) : dtrial[W-1:0];
            r_num <= {r_num[DN-2:0], dbit};
        end
        if (i_cmd.div_fin) begin
            r_deriv <= r_dneg ? W'(-qv[W-1:0]) : qv[W-1:0];
            if (r_num > qlim) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.raw_load) begin
            r_raw <= (W+2)'(r_mres);
        end else if (i_cmd.raw_add) begin
            r_raw <= r_raw + (W+2)'(r_mres);
        end
        if (i_cmd.chk) begin
            r_above <= above;
            r_below <= below;
            if (drive_sat.flag) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.edt_save) begin
            r_edt <= r_mres;
        end
        if (i_cmd.back && back_sat.flag) begin
            r_sat <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out <= OUT_TW'({r_zero, r_sat, r_below, r_above, drive_sat.val});
        end
    end

endmodule

>>> sv/pid_trapezoid_antiwindup_top.sv
// PID controller with trapezoidal integral and back-calculation anti-windup.
// Input stream: one beat per sample; tdata carries measured (bits 31:0, signed
// Q16.16) and time_step (bits 62:32, unsigned Q15.16). Output stream: one beat
// per sample; tdata carries drive (31:0), above_limit (32), below_limit (33),
// saturated (34) and zero_step (35).
// The user writes gains, target and the two limits on the cfg port only while
// idle; the block itself does not enforce this. One multiplier is shared by all
// products, and D comes from a restoring divider retiring one quotient bit a
// cycle. A sample skips the divider when time_step is zero and adds the
// back-calculation steps when a limit is crossed; the next sample is
// accepted in the cycle after the result is loaded.
// The result sits in an output register, so a stalled receiver only holds the
// controller once the next result is ready and the previous is still waiting.
// Reset (synchronous, active low) clears the integral and previous error,
// loads the register defaults and drops the output valid.
module pid_trapezoid_antiwindup_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pidtaw_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  logic [pidtaw_pkg::W-1:0]           i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [pidtaw_pkg::IN_TW-1:0]       i_s_tdata,   // measured, time_step
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [pidtaw_pkg::OUT_TW-1:0]      o_m_tdata    // drive, above_limit,
                                                            // below_limit, saturated,
                                                            // zero_step
);
    import pidtaw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pidtaw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pidtaw_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tdata  (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a sample is in work");

    a_limits_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[W] && o_m_tdata[W+1]))
        else $error("both limit flags set");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("block not idle after reset");
`endif

endmodule
